[hw/rtl/wlb_pkg.sv]
// ----------------------------------------------------------------------------
// wlb_pkg
// Shared types and constants of the weighted curve blending pixel core.
// ----------------------------------------------------------------------------
package wlb_pkg;

    localparam int CURVE_COUNT = 9;
    localparam int CURVE_NODES = 256;
    localparam int CHANNELS    = 3;
    localparam int MAX_COEFS   = 9;

    localparam int FULL_SCALE  = 255;
    localparam int Q_SHIFT     = 28;

    localparam int COEF_W      = 16;
    localparam int PROD_W      = 2 * COEF_W;
    localparam int SUM_W       = PROD_W + $clog2(CURVE_COUNT + 1);
    localparam int SCALED_W    = SUM_W + 8;
    localparam int CHAN_W      = 2;
    localparam int LEVEL_W     = 8;
    localparam int PIXEL_W     = 8;

    localparam int TABLE_ROWS  = CHANNELS * CURVE_NODES;
    localparam int ROW_AW      = $clog2(TABLE_ROWS);

    localparam int GROUP       = 3;
    localparam int NGROUP      = (CURVE_COUNT + GROUP - 1) / GROUP;

    localparam logic MODE_BLEND = 1'b0;
    localparam logic MODE_LOAD  = 1'b1;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic [ROW_AW-1:0]        row_t;

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic en4;
        logic en5;
    } pipe_ctrl_t;

endpackage

[hw/rtl/wlb_lane.sv]
// ----------------------------------------------------------------------------
// wlb_lane
// One curve lane: its own bank of curve values, registered read and product.
// ----------------------------------------------------------------------------
module wlb_lane (
    input  logic               clk,
    input  wlb_pkg::pipe_ctrl_t ctrl,
    input  logic               wr_en,
    input  wlb_pkg::row_t      wr_row,
    input  wlb_pkg::coef_t     wr_data,
    input  logic               rd_ok,
    input  wlb_pkg::row_t      rd_row,
    input  wlb_pkg::coef_t     weight,
    output wlb_pkg::prod_t     prod
);
    import wlb_pkg::*;

    coef_t mem [TABLE_ROWS];
    coef_t rdata_reg;
    coef_t weight_reg;
    logic  rd_ok_reg;
    prod_t prod_reg;
    prod_t prod_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_row] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en1)
        begin
            rdata_reg  <= mem[rd_row];
            weight_reg <= weight;
            rd_ok_reg  <= rd_ok;
        end
    end

    // missing channel reads row zero but gives a zero product
    assign prod_next = rd_ok_reg ? prod_t'(rdata_reg) * prod_t'(weight_reg) : '0;

    always_ff @(posedge clk)
    begin
        if (ctrl.en2)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

[hw/rtl/wlb_merge.sv]
// ----------------------------------------------------------------------------
// wlb_merge
// Sums the lane products over two registered levels, scales and clamps.
// ----------------------------------------------------------------------------
module wlb_merge (
    input  logic                      clk,
    input  wlb_pkg::pipe_ctrl_t       ctrl,
    input  wlb_pkg::prod_t            prod [wlb_pkg::CURVE_COUNT],
    output logic [wlb_pkg::PIXEL_W-1:0] pixel
);
    import wlb_pkg::*;

    sum_t                group_reg [NGROUP];
    sum_t                group_next [NGROUP];
    sum_t                total_reg;
    sum_t                total_next;
    logic [SCALED_W-1:0] scaled;
    logic [SCALED_W-1:0] shifted;
    logic [PIXEL_W-1:0]  pixel_reg;
    logic [PIXEL_W-1:0]  pixel_next;

    // partial sums of up to three products each
    always_comb
    begin
        for (int g = 0; g < NGROUP; g++)
        begin
            group_next[g] = '0;
            for (int j = 0; j < GROUP; j++)
            begin
                if (g * GROUP + j < CURVE_COUNT)
                begin
                    group_next[g] = group_next[g] + sum_t'(prod[g * GROUP + j]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en3)
        begin
            group_reg <= group_next;
        end
    end

    always_comb
    begin
        total_next = '0;
        for (int g = 0; g < NGROUP; g++)
        begin
            total_next = total_next + group_reg[g];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en4)
        begin
            total_reg <= total_next;
        end
    end

    assign scaled  = SCALED_W'(unsigned'(total_reg)) * SCALED_W'(FULL_SCALE);
    assign shifted = scaled >> Q_SHIFT;

    always_comb
    begin
        if (total_reg <= sum_t'(0))
        begin
            pixel_next = '0;
        end
        else if (shifted > SCALED_W'(FULL_SCALE))
        begin
            pixel_next = PIXEL_W'(FULL_SCALE);
        end
        else
        begin
            pixel_next = shifted[PIXEL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en5)
        begin
            pixel_reg <= pixel_next;
        end
    end

    assign pixel = pixel_reg;

endmodule

[hw/rtl/weighted_lut_blend_pixel_core.sv]
// ----------------------------------------------------------------------------
// weighted_lut_blend_pixel_core
// A blend item passes the read, product, group sum, total and output stages
// and raises out_valid with the last. Throughput: one item per cycle unless
// out_stall backs up the pipeline; each curve lane has its own table bank.
// A load item writes its row at the accept edge and gives no result. Reset
// clears the pipeline valid bits; table rows are undefined until loaded.
// ----------------------------------------------------------------------------
module weighted_lut_blend_pixel_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              mode,
    input  logic [wlb_pkg::CHAN_W-1:0]        channel_sel,
    input  logic [wlb_pkg::LEVEL_W-1:0]       level,
    input  wlb_pkg::coef_t                    coef_0,
    input  wlb_pkg::coef_t                    coef_1,
    input  wlb_pkg::coef_t                    coef_2,
    input  wlb_pkg::coef_t                    coef_3,
    input  wlb_pkg::coef_t                    coef_4,
    input  wlb_pkg::coef_t                    coef_5,
    input  wlb_pkg::coef_t                    coef_6,
    input  wlb_pkg::coef_t                    coef_7,
    input  wlb_pkg::coef_t                    coef_8,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [wlb_pkg::PIXEL_W-1:0]       pixel_out
);
    import wlb_pkg::*;

    coef_t      coef_all [MAX_COEFS];
    prod_t      prod [CURVE_COUNT];
    pipe_ctrl_t ctrl;
    logic       ch_ok;
    row_t       row_idx;
    logic       wr_en;
    logic       blend_in;
    logic       v1_reg;
    logic       v2_reg;
    logic       v3_reg;
    logic       v4_reg;
    logic       out_valid_reg;

    assign coef_all[0] = coef_0;
    assign coef_all[1] = coef_1;
    assign coef_all[2] = coef_2;
    assign coef_all[3] = coef_3;
    assign coef_all[4] = coef_4;
    assign coef_all[5] = coef_5;
    assign coef_all[6] = coef_6;
    assign coef_all[7] = coef_7;
    assign coef_all[8] = coef_8;

    // each stage moves when its successor is empty or moving
    assign ctrl.en5 = !out_valid_reg || !out_stall;
    assign ctrl.en4 = !v4_reg || ctrl.en5;
    assign ctrl.en3 = !v3_reg || ctrl.en4;
    assign ctrl.en2 = !v2_reg || ctrl.en3;
    assign ctrl.en1 = !v1_reg || ctrl.en2;

    assign in_stall = !ctrl.en1;

    assign ch_ok    = channel_sel < CHAN_W'(CHANNELS);
    assign row_idx  = ch_ok ? ROW_AW'(int'(channel_sel) * CURVE_NODES + int'(level)) : '0;
    assign wr_en    = in_valid && !in_stall && (mode == MODE_LOAD) && ch_ok;
    assign blend_in = in_valid && (mode == MODE_BLEND);

    for (genvar k = 0; k < CURVE_COUNT; k++)
    begin : g_lane
        wlb_lane u_lane (
            .clk     (clk),
            .ctrl    (ctrl),
            .wr_en   (wr_en),
            .wr_row  (row_idx),
            .wr_data (coef_all[k]),
            .rd_ok   (ch_ok),
            .rd_row  (row_idx),
            .weight  (ch_ok ? coef_all[k] : coef_t'(0)),
            .prod    (prod[k])
        );
    end

    wlb_merge u_merge (
        .clk   (clk),
        .ctrl  (ctrl),
        .prod  (prod),
        .pixel (pixel_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.en1)
            begin
                v1_reg <= blend_in;
            end
            if (ctrl.en2)
            begin
                v2_reg <= v1_reg;
            end
            if (ctrl.en3)
            begin
                v3_reg <= v2_reg;
            end
            if (ctrl.en4)
            begin
                v4_reg <= v3_reg;
            end
            if (ctrl.en5)
            begin
                out_valid_reg <= v4_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;

    // free output means the whole pipeline moves
    a_no_stall_when_free : assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && out_stall) |-> !in_stall)
        else $error("input stalled while output is free");

    // stall on input only with a full first stage
    a_stall_needs_item : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> v1_reg)
        else $error("input stalled with empty first stage");

    // a load item never enters the result pipeline
    a_load_no_result : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && mode == MODE_LOAD) |=> !v1_reg)
        else $error("load item entered result pipeline");

    // last sum stage hands its item to the output register
    a_last_stage_moves : assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && ctrl.en5) |=> out_valid)
        else $error("item lost before output register");

endmodule

[tb/sv/wlb_blend_checker.sv]
// ----------------------------------------------------------------------------
// wlb_blend_checker
// Watches all channels of the pixel core. It keeps its own copy of the curve
// table, predicts the blended level of every accepted blend item and compares
// each accepted pixel_out with the oldest pending prediction.
// ----------------------------------------------------------------------------
module wlb_blend_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic                        mode,
    input  logic [wlb_pkg::CHAN_W-1:0]  channel_sel,
    input  logic [wlb_pkg::LEVEL_W-1:0] level,
    input  wlb_pkg::coef_t              coef_0,
    input  wlb_pkg::coef_t              coef_1,
    input  wlb_pkg::coef_t              coef_2,
    input  wlb_pkg::coef_t              coef_3,
    input  wlb_pkg::coef_t              coef_4,
    input  wlb_pkg::coef_t              coef_5,
    input  wlb_pkg::coef_t              coef_6,
    input  wlb_pkg::coef_t              coef_7,
    input  wlb_pkg::coef_t              coef_8,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [wlb_pkg::PIXEL_W-1:0] pixel_out,
    output int                          pending_pixels,
    output int                          fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    wlb_pkg::coef_t               curve_rows [wlb_pkg::TABLE_ROWS][wlb_pkg::CURVE_COUNT];
    wlb_pkg::coef_t               taps [wlb_pkg::CURVE_COUNT];
    logic [wlb_pkg::PIXEL_W-1:0]  blended_levels_q [$];
    logic [wlb_pkg::PIXEL_W-1:0]  want;
    int                           mismatch_count = 0;
    int                           row;

    assign fail_count = mismatch_count;

    function automatic logic [wlb_pkg::PIXEL_W-1:0] blend_level(
        input logic [wlb_pkg::CHAN_W-1:0]  ch,
        input logic [wlb_pkg::LEVEL_W-1:0] lv,
        input wlb_pkg::coef_t              w [wlb_pkg::CURVE_COUNT]
    );
        longint acc;
        longint scaled;
        int     r;
        if (int'(ch) >= wlb_pkg::CHANNELS)
            return '0;
        r   = int'(ch) * wlb_pkg::CURVE_NODES + int'(lv);
        acc = 0;
        for (int k = 0; k < wlb_pkg::CURVE_COUNT; k++)
            acc += longint'(w[k]) * longint'(curve_rows[r][k]);
        if (acc <= 0)
            return '0;
        scaled = (acc * longint'(wlb_pkg::FULL_SCALE)) >>> wlb_pkg::Q_SHIFT;
        if (scaled > longint'(wlb_pkg::FULL_SCALE))
            scaled = longint'(wlb_pkg::FULL_SCALE);
        return scaled[wlb_pkg::PIXEL_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blended_levels_q.delete();
            pending_pixels <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (blended_levels_q.size() == 0)
                begin
                    $display("%0t: pixel_out %0d arrived with nothing expected", $time,
                             pixel_out);
                    mismatch_count++;
                end
                else
                begin
                    want = blended_levels_q.pop_front();
                    if (pixel_out !== want)
                    begin
                        $display("%0t: pixel_out mismatch, expected %0d, actual %0d", $time,
                                 want, pixel_out);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                taps[0] = coef_0;
                taps[1] = coef_1;
                taps[2] = coef_2;
                taps[3] = coef_3;
                taps[4] = coef_4;
                taps[5] = coef_5;
                taps[6] = coef_6;
                taps[7] = coef_7;
                taps[8] = coef_8;
                if (mode == wlb_pkg::MODE_LOAD)
                begin
                    if (int'(channel_sel) < wlb_pkg::CHANNELS)
                    begin
                        row = int'(channel_sel) * wlb_pkg::CURVE_NODES + int'(level);
                        for (int k = 0; k < wlb_pkg::CURVE_COUNT; k++)
                            curve_rows[row][k] = taps[k];
                    end
                end
                else
                    blended_levels_q.push_back(blend_level(channel_sel, level, taps));
            end
            pending_pixels <= blended_levels_q.size();
        end
    end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the weighted curve blending pixel core. Loads curve
// rows, then blends only loaded rows or the missing channel, directed corner
// items first and random ones after, under random idling, a long output
// hold-off and a full drain in between. The checker beside the core compares.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 900;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 20;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic                        mode;
    logic [wlb_pkg::CHAN_W-1:0]  channel_sel;
    logic [wlb_pkg::LEVEL_W-1:0] level;
    wlb_pkg::coef_t              coef_in [wlb_pkg::CURVE_COUNT];
    logic                        out_valid;
    logic                        out_stall;
    logic [wlb_pkg::PIXEL_W-1:0] pixel_out;
    int                          pending_pixels;
    int                          fail_count;

    wlb_pkg::coef_t              next_coef [wlb_pkg::CURVE_COUNT];
    bit                          row_loaded [wlb_pkg::TABLE_ROWS];
    int                          loaded_rows [$];
    bit                          send_idle = 1'b1;
    bit                          recv_idle = 1'b1;
    logic                        long_hold_req = 1'b0;

    always #10 clk = ~clk;

    weighted_lut_blend_pixel_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .channel_sel (channel_sel),
        .level       (level),
        .coef_0      (coef_in[0]),
        .coef_1      (coef_in[1]),
        .coef_2      (coef_in[2]),
        .coef_3      (coef_in[3]),
        .coef_4      (coef_in[4]),
        .coef_5      (coef_in[5]),
        .coef_6      (coef_in[6]),
        .coef_7      (coef_in[7]),
        .coef_8      (coef_in[8]),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_out   (pixel_out)
    );

    wlb_blend_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .channel_sel    (channel_sel),
        .level          (level),
        .coef_0         (coef_in[0]),
        .coef_1         (coef_in[1]),
        .coef_2         (coef_in[2]),
        .coef_3         (coef_in[3]),
        .coef_4         (coef_in[4]),
        .coef_5         (coef_in[5]),
        .coef_6         (coef_in[6]),
        .coef_7         (coef_in[7]),
        .coef_8         (coef_in[8]),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pixel_out      (pixel_out),
        .pending_pixels (pending_pixels),
        .fail_count     (fail_count)
    );

    function automatic void fill_all(input int v);
        for (int k = 0; k < wlb_pkg::CURVE_COUNT; k++)
            next_coef[k] = wlb_pkg::coef_t'(v);
    endfunction

    task automatic offer_item(
        input logic                        m,
        input logic [wlb_pkg::CHAN_W-1:0]  ch,
        input logic [wlb_pkg::LEVEL_W-1:0] lv
    );
        int r;
        while (send_idle && $urandom_range(99) < 36)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        mode        <= m;
        channel_sel <= ch;
        level       <= lv;
        for (int k = 0; k < wlb_pkg::CURVE_COUNT; k++)
            coef_in[k] <= next_coef[k];
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = int'(ch) * wlb_pkg::CURVE_NODES + int'(lv);
        if (m == wlb_pkg::MODE_LOAD && int'(ch) < wlb_pkg::CHANNELS && !row_loaded[r])
        begin
            row_loaded[r] = 1'b1;
            loaded_rows.push_back(r);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels != 0)
            @(posedge clk);
    endtask

    // output side stall, with one long hold-off on request
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD - 1)
                    @(posedge clk);
            end
            else
                out_stall <= recv_idle && ($urandom_range(99) < 36);
        end
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        logic                        m;
        logic [wlb_pkg::CHAN_W-1:0]  ch;
        logic [wlb_pkg::LEVEL_W-1:0] lv;
        int                          follow_row;
        int                          pick;
        int                          r;
        int                          shape;

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        mode        <= wlb_pkg::MODE_BLEND;
        channel_sel <= '0;
        level       <= '0;
        for (int k = 0; k < wlb_pkg::CURVE_COUNT; k++)
            coef_in[k] <= '0;
        fill_all(0);
        follow_row = -1;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extreme rows and one exact row
        fill_all(32767);
        offer_item(wlb_pkg::MODE_LOAD, 2'd0, 8'd0);
        fill_all(-32768);
        offer_item(wlb_pkg::MODE_LOAD, 2'd2, 8'd255);
        fill_all(0);
        next_coef[0] = wlb_pkg::coef_t'(16384);
        next_coef[1] = wlb_pkg::coef_t'(8192);
        next_coef[2] = wlb_pkg::coef_t'(-16384);
        next_coef[8] = wlb_pkg::coef_t'(1);
        offer_item(wlb_pkg::MODE_LOAD, 2'd1, 8'd128);
        // load to a channel that does not exist is dropped
        fill_all('h1234);
        offer_item(wlb_pkg::MODE_LOAD, 2'(wlb_pkg::CHANNELS), 8'd0);

        fill_all(32767);
        offer_item(wlb_pkg::MODE_BLEND, 2'd0, 8'd0);
        fill_all(-32768);
        offer_item(wlb_pkg::MODE_BLEND, 2'd0, 8'd0);
        offer_item(wlb_pkg::MODE_BLEND, 2'd2, 8'd255);
        fill_all(32767);
        offer_item(wlb_pkg::MODE_BLEND, 2'd2, 8'd255);
        // exactly one, one half, negative, zero, smallest positive sum
        fill_all(0);
        next_coef[0] = wlb_pkg::coef_t'(16384);
        offer_item(wlb_pkg::MODE_BLEND, 2'd1, 8'd128);
        fill_all(0);
        next_coef[1] = wlb_pkg::coef_t'(16384);
        offer_item(wlb_pkg::MODE_BLEND, 2'd1, 8'd128);
        fill_all(0);
        next_coef[2] = wlb_pkg::coef_t'(16384);
        offer_item(wlb_pkg::MODE_BLEND, 2'd1, 8'd128);
        fill_all(0);
        offer_item(wlb_pkg::MODE_BLEND, 2'd1, 8'd128);
        next_coef[8] = wlb_pkg::coef_t'(1);
        offer_item(wlb_pkg::MODE_BLEND, 2'd1, 8'd128);
        // blends on the missing channel give zero
        fill_all(32767);
        offer_item(wlb_pkg::MODE_BLEND, 2'(wlb_pkg::CHANNELS), 8'd0);
        offer_item(wlb_pkg::MODE_BLEND, 2'(wlb_pkg::CHANNELS), 8'd255);
        // overwrite then read the same row right away
        fill_all(16383);
        offer_item(wlb_pkg::MODE_LOAD, 2'd1, 8'd128);
        fill_all(0);
        next_coef[0] = wlb_pkg::coef_t'(16384);
        offer_item(wlb_pkg::MODE_BLEND, 2'd1, 8'd128);
        fill_all(1);
        offer_item(wlb_pkg::MODE_LOAD, 2'd0, 8'd0);
        fill_all(32767);
        offer_item(wlb_pkg::MODE_BLEND, 2'd0, 8'd0);
        for (int k = 0; k < wlb_pkg::CURVE_COUNT; k++)
            next_coef[k] = (k % 2 == 0) ? 16'h5555 : 16'haaaa;
        offer_item(wlb_pkg::MODE_LOAD, 2'd2, 8'd170);
        for (int k = 0; k < wlb_pkg::CURVE_COUNT; k++)
            next_coef[k] = (k % 2 == 0) ? 16'haaaa : 16'h5555;
        offer_item(wlb_pkg::MODE_BLEND, 2'd2, 8'd170);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            send_idle = !(i >= 300 && i < 520);
            recv_idle = send_idle;
            if (i == 330)
                long_hold_req <= 1'b1;
            if (i == 650)
                wait_drained();

            pick = $urandom_range(99);
            if (follow_row >= 0 && pick < 50)
            begin
                m  = wlb_pkg::MODE_BLEND;
                r  = follow_row;
                ch = 2'(r / wlb_pkg::CURVE_NODES);
                lv = 8'(r % wlb_pkg::CURVE_NODES);
            end
            else if (pick < 30)
            begin
                m  = wlb_pkg::MODE_LOAD;
                ch = ($urandom_range(99) < 6) ? 2'(wlb_pkg::CHANNELS)
                                              : 2'($urandom_range(wlb_pkg::CHANNELS - 1));
                lv = 8'($urandom);
            end
            else if (pick < 35)
            begin
                m  = wlb_pkg::MODE_BLEND;
                ch = 2'(wlb_pkg::CHANNELS);
                lv = 8'($urandom);
            end
            else
            begin
                m  = wlb_pkg::MODE_BLEND;
                r  = loaded_rows[$urandom_range(loaded_rows.size() - 1)];
                ch = 2'(r / wlb_pkg::CURVE_NODES);
                lv = 8'(r % wlb_pkg::CURVE_NODES);
            end

            shape = $urandom_range(99);
            for (int k = 0; k < wlb_pkg::CURVE_COUNT; k++)
            begin
                if (m == wlb_pkg::MODE_LOAD)
                    next_coef[k] = (shape < 50) ? wlb_pkg::coef_t'($urandom_range(16384))
                                                : wlb_pkg::coef_t'($urandom);
                else if (shape < 55)
                    next_coef[k] = wlb_pkg::coef_t'($urandom_range(3000));
                else if (shape < 75)
                    next_coef[k] = wlb_pkg::coef_t'(int'($urandom_range(8000)) - 4000);
                else
                    next_coef[k] = wlb_pkg::coef_t'($urandom);
            end

            offer_item(m, ch, lv);
            if (m == wlb_pkg::MODE_LOAD && int'(ch) < wlb_pkg::CHANNELS)
                follow_row = int'(ch) * wlb_pkg::CURVE_NODES + int'(lv);
            else
                follow_row = -1;
        end

        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fail_count == 0 && pending_pixels == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/wlb_pkg.sv
hw/rtl/wlb_lane.sv
hw/rtl/wlb_merge.sv
hw/rtl/weighted_lut_blend_pixel_core.sv
tb/sv/wlb_blend_checker.sv
tb/sv/tb.sv
